FILE: sv/dlpv_pkg.sv
// ----------------------------------------------------------------------------
// dlpv_pkg
// Shared types and constants of the device-list payload validator.
// ----------------------------------------------------------------------------
package dlpv_pkg;

    localparam int unsigned MaxRecordsDef     = 128;
    localparam int unsigned MaxStringBytesDef = 4095;

    localparam logic [31:0] MagicReset   = 32'h4344414C;
    localparam logic [15:0] VersionReset = 16'd1;
    localparam logic [16:0] MaxPayReset  = 17'd65536;
    localparam logic [7:0]  MaxRecReset  = 8'd128;
    localparam logic [11:0] MaxIdReset   = 12'd4000;
    localparam logic [11:0] MaxNameReset = 12'd1000;

    localparam logic [2:0] CfgMagic   = 3'd0;
    localparam logic [2:0] CfgVersion = 3'd1;
    localparam logic [2:0] CfgMaxPay  = 3'd2;
    localparam logic [2:0] CfgMaxRec  = 3'd3;
    localparam logic [2:0] CfgMaxId   = 3'd4;
    localparam logic [2:0] CfgMaxName = 3'd5;

    localparam logic [3:0] StOk      = 4'd0;
    localparam logic [3:0] StLength  = 4'd1;
    localparam logic [3:0] StMagic   = 4'd2;
    localparam logic [3:0] StVersion = 4'd3;
    localparam logic [3:0] StCount   = 4'd4;
    localparam logic [3:0] StFlags   = 4'd5;
    localparam logic [3:0] StTrail   = 4'd6;
    localparam logic [3:0] StIdent   = 4'd7;
    localparam logic [3:0] StName    = 4'd8;
    localparam logic [3:0] StUtf8    = 4'd9;
    localparam logic [3:0] StMultDef = 4'd10;

    localparam logic [2:0] KindHeader  = 3'd0;
    localparam logic [2:0] KindFlags   = 3'd1;
    localparam logic [2:0] KindIdLen   = 3'd2;
    localparam logic [2:0] KindNameLen = 3'd3;
    localparam logic [2:0] KindIdByte  = 3'd4;
    localparam logic [2:0] KindNameByte = 3'd5;
    localparam logic [2:0] KindSurplus = 3'd6;

    // Queue entry between front and back: one byte with its tags.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [2:0] kind;
        logic [6:0] rec;
        logic       dflt;
        logic [3:0] status;
    } t_entry;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [16:0] max_pay;
        logic [7:0]  max_rec;
        logic [11:0] max_id;
        logic [11:0] max_name;
    } t_cfg;

endpackage

FILE: sv/device_list_payload_validator_top.sv
// ----------------------------------------------------------------------------
// device_list_payload_validator_top
// Byte-serial validator for device-list payloads.
// ----------------------------------------------------------------------------
// Usage. Payload bytes arrive on the input channel (i_valid, o_stall), one
// item per byte, with i_end_of_payload set on the last byte. Each item gives
// exactly one result item on the output channel (o_valid, i_stall): the byte,
// its field kind, record index and default flag, and on the last byte the
// final status of the whole payload.
// The parser classifies each byte in the cycle it is accepted and writes the
// tagged item into a two-entry queue; the registered item appears on the
// output once the items ahead of it are taken. The parser takes one item per
// cycle while the queue has room. When the receiver stalls, the queue absorbs
// up to two items and then o_stall is raised until room returns.
// Reset (synchronous, active low) empties the queue, returns the parser to
// the start of a payload and loads the register defaults. The user writes the
// registers through the configuration channel (i_cfg_valid, o_cfg_ready)
// only while no payload is in progress; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module device_list_payload_validator_top #(
    parameter int unsigned MAX_RECORDS      = dlpv_pkg::MaxRecordsDef,
    parameter int unsigned MAX_STRING_BYTES = dlpv_pkg::MaxStringBytesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_payload,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_field_kind,
    output logic [6:0]  o_record_index,
    output logic        o_is_default,
    output logic        o_final_res,
    output logic [3:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    dlpv_pkg::t_cfg   cfg;
    dlpv_pkg::t_entry fe, qe;
    logic             full, take, pop;

    // Registers are always writable; the user keeps writes to idle times.
    assign o_cfg_ready = 1'b1;

    dlpv_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data), .o_cfg(cfg)
    );

    assign o_stall = full;
    assign take    = i_valid && !full;

    dlpv_front #(.MAX_RECORDS(MAX_RECORDS), .MAX_STRING_BYTES(MAX_STRING_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_data(i_data_byte),
        .i_last(i_end_of_payload), .i_cfg(cfg), .o_entry(fe)
    );

    assign pop = o_valid && !i_stall;

    dlpv_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(take), .i_entry(fe),
        .o_full(full), .o_valid(o_valid), .i_pop(pop), .o_entry(qe)
    );

    assign o_out_byte     = qe.data;
    assign o_field_kind   = qe.kind;
    assign o_record_index = qe.rec;
    assign o_is_default   = qe.dflt;
    assign o_final_res    = qe.last;
    assign o_status       = qe.status;
endmodule

FILE: sv/dlpv_cfg.sv
// ----------------------------------------------------------------------------
// dlpv_cfg
// Configuration register file with write port.
// ----------------------------------------------------------------------------
module dlpv_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [2:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    output dlpv_pkg::t_cfg   o_cfg
);
    dlpv_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic    <= dlpv_pkg::MagicReset;
            r_cfg.version  <= dlpv_pkg::VersionReset;
            r_cfg.max_pay  <= dlpv_pkg::MaxPayReset;
            r_cfg.max_rec  <= dlpv_pkg::MaxRecReset;
            r_cfg.max_id   <= dlpv_pkg::MaxIdReset;
            r_cfg.max_name <= dlpv_pkg::MaxNameReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dlpv_pkg::CfgMagic:   r_cfg.magic    <= i_cfg_data;
                dlpv_pkg::CfgVersion: r_cfg.version  <= i_cfg_data[15:0];
                dlpv_pkg::CfgMaxPay:  r_cfg.max_pay  <= i_cfg_data[16:0];
                dlpv_pkg::CfgMaxRec:  r_cfg.max_rec  <= i_cfg_data[7:0];
                dlpv_pkg::CfgMaxId:   r_cfg.max_id   <= i_cfg_data[11:0];
                dlpv_pkg::CfgMaxName: r_cfg.max_name <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

FILE: sv/dlpv_front.sv
// ----------------------------------------------------------------------------
// dlpv_front
// Parser: classifies each accepted byte and works out the final status.
// ----------------------------------------------------------------------------
module dlpv_front #(
    parameter int unsigned MAX_RECORDS      = dlpv_pkg::MaxRecordsDef,
    parameter int unsigned MAX_STRING_BYTES = dlpv_pkg::MaxStringBytesDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_data,
    input  logic             i_last,
    input  dlpv_pkg::t_cfg   i_cfg,
    output dlpv_pkg::t_entry o_entry
);
    localparam logic [16:0] MaxRecL = 17'(MAX_RECORDS);
    localparam logic [31:0] MaxStrL = 32'(MAX_STRING_BYTES);

    typedef enum logic [3:0] {
        PH_MAGIC, PH_VERSION, PH_COUNT, PH_FLAGS, PH_IDLEN, PH_NAMELEN,
        PH_IDSTR, PH_NAMESTR, PH_SURPLUS, PH_STOPPED
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_shift, n_shift;
    logic [1:0]  r_fcnt, n_fcnt;
    logic [11:0] r_rem, n_rem;
    logic [11:0] r_nlen, n_nlen;
    logic [8:0]  r_hcnt, n_hcnt;
    logic [8:0]  r_done, n_done;
    logic [16:0] r_pcnt, n_pcnt;
    logic [3:0]  r_serr, n_serr;
    logic [3:0]  r_setr, n_setr;
    logic        r_dseen, n_dseen;
    logic [1:0]  r_upend, n_upend;
    logic [20:0] r_ucp, n_ucp;
    logic [16:0] r_umin, n_umin;
    logic [1:0]  r_sflg, n_sflg;
    logic        r_cdef, n_cdef;

    logic [31:0] sh;
    logic [1:0]  fc1;
    logic        full4, full2;
    logic [20:0] cp;
    logic [2:0]  kind;
    logic [6:0]  rec;
    logic        dflt;
    logic [3:0]  status;
    logic [11:0] remd;
    logic [1:0]  sf;
    logic        tmp_done;

    // Error helper: keeps only the first.
    function automatic logic [3:0] keep(input logic [3:0] cur, input logic [3:0] c);
        keep = (cur == dlpv_pkg::StOk) ? c : cur;
    endfunction

    always_comb begin
        n_phase = r_phase; n_shift = r_shift; n_fcnt = r_fcnt; n_rem = r_rem;
        n_nlen = r_nlen; n_hcnt = r_hcnt; n_done = r_done; n_pcnt = r_pcnt;
        n_serr = r_serr; n_setr = r_setr; n_dseen = r_dseen; n_upend = r_upend;
        n_ucp = r_ucp; n_umin = r_umin; n_sflg = r_sflg; n_cdef = r_cdef;
        kind = dlpv_pkg::KindSurplus; rec = 7'd0; dflt = 1'b0; status = dlpv_pkg::StOk;
        remd = 12'd0; sf = 2'd0; tmp_done = 1'b0; cp = 21'd0;

        sh    = {r_shift[23:0], i_data};
        fc1   = r_fcnt + 2'd1;
        full4 = (r_fcnt == 2'd3);
        full2 = (r_fcnt == 2'd1);

        if (r_pcnt != 17'h1FFFF) n_pcnt = r_pcnt + 17'd1;
        if (r_phase == PH_FLAGS || r_phase == PH_IDLEN || r_phase == PH_NAMELEN ||
            r_phase == PH_IDSTR || r_phase == PH_NAMESTR) begin
            rec = r_done[6:0];
        end

        unique case (r_phase)
            PH_MAGIC: begin
                kind = dlpv_pkg::KindHeader;
                n_shift = sh; n_fcnt = fc1;
                if (full4) begin
                    n_fcnt = 2'd0; n_shift = 32'd0;
                    if (sh != i_cfg.magic) begin
                        n_serr = keep(r_serr, dlpv_pkg::StMagic); n_phase = PH_STOPPED;
                    end else n_phase = PH_VERSION;
                end
            end
            PH_VERSION: begin
                kind = dlpv_pkg::KindHeader;
                n_shift = sh; n_fcnt = fc1;
                if (full2) begin
                    n_fcnt = 2'd0; n_shift = 32'd0;
                    if (sh[15:0] != i_cfg.version) begin
                        n_serr = keep(r_serr, dlpv_pkg::StVersion); n_phase = PH_STOPPED;
                    end else n_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                kind = dlpv_pkg::KindHeader;
                n_shift = sh; n_fcnt = fc1;
                if (full2) begin
                    n_fcnt = 2'd0; n_shift = 32'd0;
                    if ({1'b0, sh[15:0]} > {9'd0, i_cfg.max_rec} ||
                        {1'b0, sh[15:0]} > MaxRecL) begin
                        n_serr = keep(r_serr, dlpv_pkg::StCount); n_phase = PH_STOPPED;
                    end else begin
                        n_hcnt = sh[8:0]; n_done = 9'd0;
                        n_phase = (sh[15:0] == 16'd0) ? PH_SURPLUS : PH_FLAGS;
                    end
                end
            end
            PH_FLAGS: begin
                kind = dlpv_pkg::KindFlags;
                if (i_data[7:1] != 7'd0) begin
                    n_serr = keep(r_serr, dlpv_pkg::StFlags); n_phase = PH_STOPPED;
                end else begin
                    n_cdef = i_data[0]; dflt = i_data[0]; n_phase = PH_IDLEN;
                end
            end
            PH_IDLEN: begin
                kind = dlpv_pkg::KindIdLen; dflt = r_cdef;
                n_shift = sh; n_fcnt = fc1;
                if (full4) begin
                    n_fcnt = 2'd0; n_shift = 32'd0;
                    if (sh > {20'd0, i_cfg.max_id} || sh > MaxStrL) begin
                        n_serr = keep(r_serr, dlpv_pkg::StLength); n_phase = PH_STOPPED;
                    end else begin
                        n_rem = sh[11:0]; n_phase = PH_NAMELEN;
                    end
                end
            end
            PH_NAMELEN: begin
                kind = dlpv_pkg::KindNameLen; dflt = r_cdef;
                n_shift = sh; n_fcnt = fc1;
                if (full4) begin
                    n_fcnt = 2'd0; n_shift = 32'd0;
                    if (sh > {20'd0, i_cfg.max_name} || sh > MaxStrL) begin
                        n_serr = keep(r_serr, dlpv_pkg::StLength); n_phase = PH_STOPPED;
                    end else begin
                        n_nlen = sh[11:0];
                        n_sflg = 2'd0; n_upend = 2'd0; n_ucp = 21'd0; n_umin = 17'd0;
                        if (r_rem == 12'd0) begin
                            n_setr = keep(r_setr, dlpv_pkg::StIdent);
                            if (sh[11:0] == 12'd0) begin
                                tmp_done = 1'b1;
                            end else begin
                                n_rem = sh[11:0]; n_phase = PH_NAMESTR;
                            end
                        end else n_phase = PH_IDSTR;
                    end
                end
            end
            PH_IDSTR, PH_NAMESTR: begin
                kind = (r_phase == PH_IDSTR) ? dlpv_pkg::KindIdByte : dlpv_pkg::KindNameByte;
                dflt = r_cdef;
                // UTF-8 step on this byte.
                sf = r_sflg;
                if (i_data == 8'd0) sf[0] = 1'b1;
                if (!r_sflg[1]) begin
                    if (r_upend == 2'd0) begin
                        if (i_data[7]) begin
                            if (i_data[7:5] == 3'b110) begin
                                n_upend = 2'd1; n_ucp = {16'd0, i_data[4:0]}; n_umin = 17'h80;
                            end else if (i_data[7:4] == 4'b1110) begin
                                n_upend = 2'd2; n_ucp = {17'd0, i_data[3:0]}; n_umin = 17'h800;
                            end else if (i_data[7:3] == 5'b11110) begin
                                n_upend = 2'd3; n_ucp = {18'd0, i_data[2:0]};
                                n_umin = 17'h10000;
                            end else sf[1] = 1'b1;
                        end
                    end else if (i_data[7:6] != 2'b10) begin
                        sf[1] = 1'b1; n_upend = 2'd0;
                    end else begin
                        cp = {r_ucp[14:0], i_data[5:0]};
                        n_ucp = cp; n_upend = r_upend - 2'd1;
                        if (r_upend == 2'd1 &&
                            (cp < {4'd0, r_umin} || cp > 21'h10FFFF ||
                             (cp >= 21'hD800 && cp <= 21'hDFFF))) sf[1] = 1'b1;
                    end
                end
                n_sflg = sf;
                remd = (r_rem != 12'd0) ? r_rem - 12'd1 : 12'd0;
                n_rem = remd;
                if (remd == 12'd0) begin
                    if (sf[0]) begin
                        n_setr = keep(r_setr, (r_phase == PH_IDSTR) ? dlpv_pkg::StIdent
                                                                     : dlpv_pkg::StName);
                    end else if (sf[1] || n_upend != 2'd0) begin
                        n_setr = keep(r_setr, dlpv_pkg::StUtf8);
                    end
                    if (r_phase == PH_IDSTR) begin
                        n_sflg = 2'd0; n_upend = 2'd0; n_ucp = 21'd0; n_umin = 17'd0;
                        if (r_nlen == 12'd0) begin
                            tmp_done = 1'b1;
                        end else begin
                            n_rem = r_nlen; n_phase = PH_NAMESTR;
                        end
                    end else tmp_done = 1'b1;
                end
            end
            PH_SURPLUS: begin
                if (r_serr == dlpv_pkg::StOk) n_serr = dlpv_pkg::StTrail;
            end
            default: n_phase = PH_STOPPED;
        endcase

        // Record completion, including the empty-name error before it.
        if (tmp_done) begin
            if (r_phase == PH_NAMELEN || r_phase == PH_IDSTR) begin
                n_setr = keep(n_setr, dlpv_pkg::StName);
            end
            if (r_cdef && r_dseen) n_setr = keep(n_setr, dlpv_pkg::StMultDef);
            n_dseen = r_dseen | r_cdef;
            n_done = r_done + 9'd1;
            n_phase = (n_done >= r_hcnt) ? PH_SURPLUS : PH_FLAGS;
        end

        if (i_last) begin
            if (n_pcnt > i_cfg.max_pay) status = dlpv_pkg::StLength;
            else if (n_serr != dlpv_pkg::StOk) status = n_serr;
            else if (n_phase != PH_SURPLUS) status = dlpv_pkg::StLength;
            else status = n_setr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_phase <= PH_MAGIC; r_shift <= '0; r_fcnt <= '0; r_rem <= '0; r_nlen <= '0;
            r_hcnt <= '0; r_done <= '0; r_pcnt <= '0; r_serr <= '0; r_setr <= '0;
            r_dseen <= 1'b0; r_upend <= '0; r_ucp <= '0; r_umin <= '0; r_sflg <= '0;
            r_cdef <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase; r_shift <= n_shift; r_fcnt <= n_fcnt; r_rem <= n_rem;
            r_nlen <= n_nlen; r_hcnt <= n_hcnt; r_done <= n_done; r_pcnt <= n_pcnt;
            r_serr <= n_serr; r_setr <= n_setr; r_dseen <= n_dseen; r_upend <= n_upend;
            r_ucp <= n_ucp; r_umin <= n_umin; r_sflg <= n_sflg; r_cdef <= n_cdef;
        end
    end

    always_comb begin
        o_entry.data   = i_data;
        o_entry.last   = i_last;
        o_entry.kind   = kind;
        o_entry.rec    = rec;
        o_entry.dflt   = dflt;
        o_entry.status = status;
    end
endmodule

FILE: sv/dlpv_queue.sv
// ----------------------------------------------------------------------------
// dlpv_queue
// Two-entry queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module dlpv_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dlpv_pkg::t_entry i_entry,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output dlpv_pkg::t_entry o_entry
);
    dlpv_pkg::t_entry r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_entry = r_mem[r_rp];
endmodule

FILE: sv/dlpv_checker.sv
// ----------------------------------------------------------------------------
// dlpv_checker
// Port-level checks of the validator, bound to the top level.
// ----------------------------------------------------------------------------
module dlpv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_field_kind,
    input logic       o_final_res,
    input logic [3:0] o_status,
    input logic [6:0] o_record_index,
    input logic       o_is_default
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("stalled result changed");
    a_nf_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_final_res |-> o_status == dlpv_pkg::StOk)
        else $error("status on non-final result");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_field_kind <= dlpv_pkg::KindSurplus && o_status <= dlpv_pkg::StMultDef)
        else $error("kind or status out of range");
    a_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_field_kind == dlpv_pkg::KindHeader ||
                    o_field_kind == dlpv_pkg::KindSurplus)
        |-> o_record_index == 7'd0 && !o_is_default)
        else $error("header or surplus byte tagged with a record");
endmodule

bind device_list_payload_validator_top dlpv_checker u_dlpv_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_field_kind(o_field_kind), .o_final_res(o_final_res), .o_status(o_status),
    .o_record_index(o_record_index), .o_is_default(o_is_default)
);

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the device-list payload validator. Payloads are
// built as byte items (mostly well-formed with random strings, some broken),
// driven with random idling on both sides, and every result item is checked
// against a byte-level parser model kept in this file.
// ----------------------------------------------------------------------------
module testbench;
    import dlpv_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_end_of_payload;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic [2:0]  o_field_kind;
    logic [6:0]  o_record_index;
    logic        o_is_default;
    logic        o_final_res;
    logic [3:0]  o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    device_list_payload_validator_top dut (.*);

    // Parser phases of the model.
    typedef enum logic [3:0] {
        PhMagic, PhVersion, PhCount, PhFlags, PhIdLen, PhNameLen,
        PhIdStr, PhNameStr, PhSurplus, PhStopped
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    // Model registers.
    logic [31:0] cfg_magic;
    logic [15:0] cfg_version;
    logic [16:0] cfg_max_pay;
    logic [7:0]  cfg_max_rec;
    logic [11:0] cfg_max_id;
    logic [11:0] cfg_max_name;

    // Model parse state.
    t_phase      phase;
    logic [31:0] shift_acc;
    int unsigned shift_cnt;
    int unsigned str_left;
    int unsigned name_len;
    int unsigned rec_total;
    int unsigned rec_done;
    int unsigned byte_total;
    logic [3:0]  struct_err;
    logic [3:0]  set_err;
    logic        dflt_seen;
    int unsigned u8_pending;
    logic [20:0] u8_cp;
    logic [20:0] u8_min;
    logic        str_nul;
    logic        str_bad;
    logic        rec_dflt;

    t_byte_item  pending_bytes[$];
    t_entry      expected_results[$];

    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned checked_count;
    int unsigned payload_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_cycles;
    logic        sending;
    logic        in_accepted;

    localparam int unsigned CycleLimit = 400000;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("device_list_payload_validator_top test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("Mismatch on %s: got %0d, expected %0d (cycle %0d)", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    function automatic void clear_parse();
        phase = PhMagic;
        shift_acc = '0;
        shift_cnt = 0;
        str_left = 0;
        name_len = 0;
        rec_total = 0;
        rec_done = 0;
        byte_total = 0;
        struct_err = StOk;
        set_err = StOk;
        dflt_seen = 1'b0;
        u8_pending = 0;
        u8_cp = '0;
        u8_min = '0;
        str_nul = 1'b0;
        str_bad = 1'b0;
        rec_dflt = 1'b0;
    endfunction

    function automatic void raise_struct(input logic [3:0] code);
        if (struct_err == StOk) struct_err = code;
        phase = PhStopped;
    endfunction

    function automatic void raise_set(input logic [3:0] code);
        if (set_err == StOk) set_err = code;
    endfunction

    function automatic void start_string();
        str_nul = 1'b0;
        str_bad = 1'b0;
        u8_pending = 0;
        u8_cp = '0;
        u8_min = '0;
    endfunction

    function automatic void scan_utf8(input logic [7:0] b);
        if (b == 8'h00) str_nul = 1'b1;
        if (str_bad) return;
        if (u8_pending == 0) begin
            if (b < 8'h80) return;
            if ((b & 8'hE0) == 8'hC0) begin
                u8_pending = 1; u8_cp = {13'd0, b & 8'h1F}; u8_min = 21'h80;
            end else if ((b & 8'hF0) == 8'hE0) begin
                u8_pending = 2; u8_cp = {13'd0, b & 8'h0F}; u8_min = 21'h800;
            end else if ((b & 8'hF8) == 8'hF0) begin
                u8_pending = 3; u8_cp = {13'd0, b & 8'h07}; u8_min = 21'h10000;
            end else begin
                str_bad = 1'b1;
            end
            return;
        end
        if ((b & 8'hC0) != 8'h80) begin
            str_bad = 1'b1;
            u8_pending = 0;
            return;
        end
        u8_cp = {u8_cp[14:0], b[5:0]};
        u8_pending--;
        if (u8_pending == 0 && (u8_cp < u8_min || u8_cp > 21'h10FFFF ||
                                (u8_cp >= 21'hD800 && u8_cp <= 21'hDFFF)))
            str_bad = 1'b1;
    endfunction

    function automatic void close_string(input logic [3:0] code);
        if (str_nul) raise_set(code);
        else if (str_bad || u8_pending != 0) raise_set(StUtf8);
    endfunction

    function automatic void close_record();
        if (rec_dflt && dflt_seen) raise_set(StMultDef);
        dflt_seen |= rec_dflt;
        rec_done++;
        phase = (rec_done >= rec_total) ? PhSurplus : PhFlags;
    endfunction

    function automatic void open_name();
        if (name_len == 0) begin
            raise_set(StName);
            close_record();
            return;
        end
        str_left = name_len;
        start_string();
        phase = PhNameStr;
    endfunction

    function automatic logic collect(input logic [7:0] b, input int unsigned n);
        shift_acc = {shift_acc[23:0], b};
        shift_cnt++;
        if (shift_cnt < n) return 1'b0;
        shift_cnt = 0;
        return 1'b1;
    endfunction

    // Classifies one payload byte and returns its tagged result.
    function automatic t_entry classify_byte(input logic [7:0] b, input logic last);
        t_entry r;
        logic [31:0] v;
        r = '0;
        r.data = b;
        r.last = last;
        r.kind = KindSurplus;
        if (byte_total < 32'h1FFFF) byte_total++;
        if (phase >= PhFlags && phase <= PhNameStr) r.rec = rec_done[6:0];
        case (phase)
            PhMagic: begin
                r.kind = KindHeader;
                if (collect(b, 4)) begin
                    if (shift_acc != cfg_magic) raise_struct(StMagic);
                    else phase = PhVersion;
                    shift_acc = '0;
                end
            end
            PhVersion: begin
                r.kind = KindHeader;
                if (collect(b, 2)) begin
                    if (shift_acc[15:0] != cfg_version) raise_struct(StVersion);
                    else phase = PhCount;
                    shift_acc = '0;
                end
            end
            PhCount: begin
                r.kind = KindHeader;
                if (collect(b, 2)) begin
                    v = {16'd0, shift_acc[15:0]};
                    shift_acc = '0;
                    if (v > cfg_max_rec || v > MaxRecordsDef) raise_struct(StCount);
                    else begin
                        rec_total = v;
                        rec_done = 0;
                        phase = (v == 0) ? PhSurplus : PhFlags;
                    end
                end
            end
            PhFlags: begin
                r.kind = KindFlags;
                if (b[7:1] != 0) raise_struct(StFlags);
                else begin
                    rec_dflt = b[0];
                    r.dflt = rec_dflt;
                    phase = PhIdLen;
                end
            end
            PhIdLen: begin
                r.kind = KindIdLen;
                r.dflt = rec_dflt;
                if (collect(b, 4)) begin
                    v = shift_acc;
                    shift_acc = '0;
                    if (v > cfg_max_id || v > MaxStringBytesDef) raise_struct(StLength);
                    else begin
                        str_left = v;
                        phase = PhNameLen;
                    end
                end
            end
            PhNameLen: begin
                r.kind = KindNameLen;
                r.dflt = rec_dflt;
                if (collect(b, 4)) begin
                    v = shift_acc;
                    shift_acc = '0;
                    if (v > cfg_max_name || v > MaxStringBytesDef) raise_struct(StLength);
                    else begin
                        name_len = v;
                        if (str_left == 0) begin
                            raise_set(StIdent);
                            open_name();
                        end else begin
                            start_string();
                            phase = PhIdStr;
                        end
                    end
                end
            end
            PhIdStr: begin
                r.kind = KindIdByte;
                r.dflt = rec_dflt;
                scan_utf8(b);
                if (str_left > 0) str_left--;
                if (str_left == 0) begin
                    close_string(StIdent);
                    open_name();
                end
            end
            PhNameStr: begin
                r.kind = KindNameByte;
                r.dflt = rec_dflt;
                scan_utf8(b);
                if (str_left > 0) str_left--;
                if (str_left == 0) begin
                    close_string(StName);
                    close_record();
                end
            end
            PhSurplus: begin
                if (struct_err == StOk) struct_err = StTrail;
            end
            default: phase = PhStopped;
        endcase
        if (last) begin
            if (byte_total > cfg_max_pay) r.status = StLength;
            else if (struct_err != StOk) r.status = struct_err;
            else if (phase != PhSurplus) r.status = StLength;
            else r.status = set_err;
            clear_parse();
        end
        return r;
    endfunction

    // Whether the offered item was taken at the last rising edge.
    always @(posedge i_clk) begin
        in_accepted <= i_valid && !o_stall;
    end

    // Driver: inputs change at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_accepted) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_data_byte <= pending_bytes[0].data;
                i_end_of_payload <= pending_bytes[0].last;
                expected_results.insert(expected_results.size(),
                    classify_byte(pending_bytes[0].data, pending_bytes[0].last));
                void'(pending_bytes.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: a long hold-off when one is requested, random idling otherwise.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: results are sampled at the rising edge.
    always @(posedge i_clk) begin
        t_entry want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $display("Unexpected result item at cycle %0d", cycle_count);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                checked_count++;
                if (want.last) payload_count++;
                if (o_out_byte != want.data) report_mismatch("byte", o_out_byte, want.data);
                if (o_field_kind != want.kind) report_mismatch("kind", o_field_kind, want.kind);
                if (o_record_index != want.rec)
                    report_mismatch("record", o_record_index, want.rec);
                if (o_is_default != want.dflt)
                    report_mismatch("default", o_is_default, want.dflt);
                if (o_final_res != want.last)
                    report_mismatch("final", o_final_res, want.last);
                if (o_status != want.status) report_mismatch("status", o_status, want.status);
            end
        end
    end

    // Appends one byte item to the send queue.
    task automatic put_byte(input logic [7:0] b, input logic last = 1'b0);
        pending_bytes.insert(pending_bytes.size(), '{data: b, last: last});
    endtask

    task automatic put_word(input logic [31:0] w, input int unsigned n);
        for (int i = n - 1; i >= 0; i--) put_byte(w[8 * i +: 8]);
    endtask

    // Random string content: mostly ASCII, with valid and broken UTF-8 and NUL.
    task automatic put_string(input int unsigned len);
        int unsigned left;
        int unsigned pick;
        left = len;
        while (left > 0) begin
            pick = $urandom_range(99);
            if (pick < 60 || left < 4) begin
                put_byte(8'($urandom_range(1, 127)));
                left--;
            end else if (pick < 70) begin
                put_byte(8'(8'hC2 + $urandom_range(29)));
                put_byte(8'(8'h80 | $urandom_range(63)));
                left -= 2;
            end else if (pick < 78) begin
                put_byte(8'(8'hE1 + $urandom_range(11)));
                put_byte(8'(8'h80 | $urandom_range(63)));
                put_byte(8'(8'h80 | $urandom_range(63)));
                left -= 3;
            end else if (pick < 84) begin
                put_byte(8'(8'hF0 | $urandom_range(4)));
                put_byte(8'(8'h80 | $urandom_range(63)));
                put_byte(8'(8'h80 | $urandom_range(63)));
                put_byte(8'(8'h80 | $urandom_range(63)));
                left -= 4;
            end else if (pick < 88) begin
                put_byte(8'h00);
                left--;
            end else begin
                put_byte(8'($urandom_range(255)));
                left--;
            end
        end
    endtask

    // Builds a payload; damage selects how it is broken (0 means well formed).
    task automatic put_payload(input int unsigned nrec, input int unsigned damage);
        int unsigned idl;
        int unsigned nml;
        put_word(damage == 1 ? cfg_magic ^ (32'd1 << $urandom_range(31)) : cfg_magic, 4);
        put_word(damage == 2 ? 32'(cfg_version) + 32'd1 : 32'(cfg_version), 2);
        put_word(nrec, 2);
        for (int r = 0; r < nrec; r++) begin
            put_byte(damage == 3 && r == nrec - 1 ? 8'($urandom_range(2, 255))
                                                  : 8'($urandom_range(5) == 0));
            idl = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
            nml = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
            // An identifier length far beyond any limit; the bytes after it are surplus.
            if (damage == 4 && r == 0) put_word(32'h0001_0000 | $urandom, 4);
            else put_word(idl, 4);
            put_word(nml, 4);
            put_string(idl);
            put_string(nml);
        end
        if (damage == 5) put_byte(8'($urandom_range(255)));
        if (damage == 6) void'(pending_bytes.pop_back());
        if (pending_bytes.size() == 0) put_byte(8'h00);
        pending_bytes[$].last = 1'b1;
    endtask

    // Waits for the queue and all results, then lets the block settle.
    task automatic drain();
        while (pending_bytes.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CfgMagic:   cfg_magic = val;
            CfgVersion: cfg_version = val[15:0];
            CfgMaxPay:  cfg_max_pay = val[16:0];
            CfgMaxRec:  cfg_max_rec = val[7:0];
            CfgMaxId:   cfg_max_id = val[11:0];
            CfgMaxName: cfg_max_name = val[11:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_payloads(input int unsigned n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 80) put_payload($urandom_range(0, 4), 0);
            else if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(255)));
                pending_bytes[$].last = 1'b1;
            end else put_payload($urandom_range(1, 3), $urandom_range(1, 6));
            while (pending_bytes.size() > 40) @(posedge i_clk);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data_byte = '0;
        i_end_of_payload = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CfgMagic;
        i_cfg_data = '0;
        cycle_count = 0;
        error_count = 0;
        checked_count = 0;
        payload_count = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cfg_magic = MagicReset;
        cfg_version = VersionReset;
        cfg_max_pay = MaxPayReset;
        cfg_max_rec = MaxRecReset;
        cfg_max_id = MaxIdReset;
        cfg_max_name = MaxNameReset;
        clear_parse();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset settings: a good payload, the header errors,
        // a flag byte above one, a length above the limit, empty strings,
        // NUL, an overlong and a surrogate sequence, two default records,
        // trailing bytes, a truncated payload and a lone byte.
        put_payload(1, 0);
        put_payload(1, 1);
        put_payload(1, 2);
        put_word(cfg_magic, 4); put_word(32'(cfg_version), 2); put_word(32'hFFFF, 2);
        pending_bytes[$].last = 1'b1;
        put_payload(1, 3);
        put_payload(1, 4);
        put_word(cfg_magic, 4); put_word(32'(cfg_version), 2); put_word(32'd2, 2);
        put_byte(8'd1); put_word(32'd0, 4); put_word(32'd2, 4);
        put_byte(8'hC0); put_byte(8'hAF);
        put_byte(8'd1); put_word(32'd3, 4); put_word(32'd1, 4);
        put_byte(8'hED); put_byte(8'hA0); put_byte(8'h80); put_byte(8'h00);
        put_byte(8'hFF, 1'b1);
        put_payload(0, 5);
        put_payload(2, 6);
        put_byte(8'h80, 1'b1);
        drain();

        // Registers at their extremes, then back to usable values.
        write_reg(CfgMagic, 32'hFFFFFFFF);
        write_reg(CfgVersion, 32'h0000FFFF);
        write_reg(CfgMaxPay, 32'd0);
        write_reg(CfgMaxRec, 32'd0);
        write_reg(CfgMaxId, 32'd0);
        write_reg(CfgMaxName, 32'd4095);
        put_payload(0, 0);
        put_payload(1, 0);
        drain();
        write_reg(CfgMagic, 32'd0);
        write_reg(CfgVersion, 32'd0);
        write_reg(CfgMaxPay, 32'd60);
        write_reg(CfgMaxRec, 32'd3);
        write_reg(CfgMaxId, 32'd4);
        write_reg(CfgMaxName, 32'd0);
        send_idle_pct = 33;
        recv_idle_pct = 70;
        random_payloads(5);
        drain();

        // Long receiver hold-off while the sender keeps offering items.
        write_reg(CfgMagic, $urandom);
        write_reg(CfgMaxPay, 32'd65536);
        write_reg(CfgMaxRec, 32'd255);
        write_reg(CfgMaxId, 32'd4095);
        write_reg(CfgMaxName, 32'd6);
        send_idle_pct = 0;
        hold_cycles = 80;
        random_payloads(2);
        drain();

        send_idle_pct = 70;
        recv_idle_pct = 33;
        random_payloads(7);
        drain();
        write_reg(CfgMagic, MagicReset);
        write_reg(CfgVersion, 32'(VersionReset));
        write_reg(CfgMaxRec, 32'(MaxRecReset));
        write_reg(CfgMaxId, 32'(MaxIdReset));
        write_reg(CfgMaxName, 32'(MaxNameReset));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_payloads(5);
        drain();

        $display("Checked %0d result items over %0d payloads.", checked_count, payload_count);
        $display("Covered header, flag, length, string and trailing-byte errors.");
        if (error_count == 0) begin
            $display("device_list_payload_validator_top test passed");
        end else begin
            $display("device_list_payload_validator_top test failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
sv/dlpv_pkg.sv
sv/dlpv_cfg.sv
sv/dlpv_front.sv
sv/dlpv_queue.sv
sv/device_list_payload_validator_top.sv
sv/dlpv_checker.sv
tb/sv/testbench.sv
